/* hdl/cwc_pkg.sv */
// ----------------------------------------------------------------------------
// cwc_pkg - congestion window control shared definitions
// Widths, reset values, event codes and sequencer states.
// ----------------------------------------------------------------------------
package cwc_pkg;

    localparam int DEF_WINDOW_WIDTH = 24;
    localparam int DEF_SEQ_WIDTH    = 32;

    localparam int MSS_W    = 16;
    localparam int THR_W    = 24;
    localparam int TMR_W    = 20;
    localparam int SEQ_IN_W = 32;
    localparam int DIV_W    = 32;
    localparam int DUP_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [MSS_W-1:0] RST_MSS = 16'd1024;
    localparam logic [THR_W-1:0] RST_THR = 24'd65536;
    localparam logic [TMR_W-1:0] RST_TMO = 20'd100000;
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    localparam logic [DUP_W-1:0] DUP_TRIGGER = 3'd3;
    localparam logic [DUP_W-1:0] DUP_MAX     = 3'd7;

    typedef enum logic [1:0] {
        OP_ACK  = 2'd0,
        OP_SENT = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SEG_ACKED   = 2'd0,
        SEG_UNACKED = 2'd1,
        SEG_OUTSIDE = 2'd2,
        SEG_UNKNOWN = 2'd3
    } t_seg;

    typedef enum logic [1:0] {
        PH_SLOW     = 2'd0,
        PH_AVOID    = 2'd1,
        PH_RECOVERY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_FAST    = 2'd1,
        EV_TIMEOUT = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MSS = 2'd0,
        CFG_THR = 2'd1,
        CFG_TMO = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_GROW,
        S_GWAIT,
        S_BUDGET,
        S_BWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

endpackage

/* hdl/cwc_div.sv */
// ----------------------------------------------------------------------------
// cwc_div - shared restoring divider
// One quotient bit per cycle; done pulses for a single cycle, together with the final quotient.
// ----------------------------------------------------------------------------
module cwc_div #(
    parameter int WINDOW_WIDTH = cwc_pkg::DEF_WINDOW_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cwc_pkg::t_div_req          i_req,
    input  logic [WINDOW_WIDTH-1:0]    i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [cwc_pkg::DIV_W-1:0]  o_quotient
);

    localparam int DW    = cwc_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [DW-1:0]           r_work;
    logic [WINDOW_WIDTH-1:0] r_rem;
    logic [WINDOW_WIDTH-1:0] r_dvs;

    logic [WINDOW_WIDTH:0]   rem_sh;
    logic [WINDOW_WIDTH:0]   rem_sub;
    logic                    ge;

    assign rem_sh  = {r_rem, r_work[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[DW-2:0], ge};
            r_rem  <= ge ? rem_sub[WINDOW_WIDTH-1:0] : rem_sh[WINDOW_WIDTH-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

/* hdl/tcp_congestion_window_control_core.sv */
// ----------------------------------------------------------------------------
// tcp_congestion_window_control_core - Reno-style congestion window control
// ACK, segment-sent and timer-tick events update window, threshold and timer.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result; a new request is
// taken only once the result has left the output, and an output stall holds
// the result until it is taken. Each request ends with the 32-step send
// budget divide (window / segment size), skipped for a zero segment size. A
// new ACK in congestion avoidance first runs the growth divide (segment size
// squared / window), which a zero window skips. Both divides go through one
// shared restoring divider producing one quotient bit per cycle. The block is
// ready right after reset.
module tcp_congestion_window_control_core #(
    parameter int WINDOW_WIDTH = cwc_pkg::DEF_WINDOW_WIDTH,
    parameter int SEQ_WIDTH    = cwc_pkg::DEF_SEQ_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] seq_or_ack, [33:32] seg_status, [39:34] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] window_bytes, [47:24] threshold_bytes, [49:48] phase,
    // [73:50] send_budget, [75:74] retransmit_event, [76] timer_active,
    // [79:77] zero
    output logic [79:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [cwc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cwc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW    = WINDOW_WIDTH;
    localparam int SW    = SEQ_WIDTH;
    localparam int SUM_W = cwc_pkg::DIV_W + 1;
    localparam logic [WW-1:0]    WMAX     = {WW{1'b1}};
    localparam logic [SUM_W-1:0] WMAX_EXT = SUM_W'(WMAX);

    cwc_pkg::t_state                 r_state, n_state;
    logic [cwc_pkg::MSS_W-1:0]       r_mss, n_mss;
    logic [cwc_pkg::TMR_W-1:0]       r_tmo, n_tmo;
    logic [WW-1:0]                   r_window, n_window;
    logic [cwc_pkg::THR_W-1:0]       r_thr, n_thr;
    cwc_pkg::t_phase                 r_phase, n_phase;
    logic [cwc_pkg::DUP_W-1:0]       r_dup, n_dup;
    logic [SW-1:0]                   r_last_ack, n_last_ack;
    logic                            r_last_valid, n_last_valid;
    logic [SW-1:0]                   r_base, n_base;
    logic                            r_armed, n_armed;
    logic [cwc_pkg::TMR_W-1:0]       r_left, n_left;
    cwc_pkg::t_event                 r_ev, n_ev;
    logic [cwc_pkg::THR_W-1:0]       r_budget, n_budget;
    logic [cwc_pkg::DIV_W-1:0]       r_sq, n_sq;

    cwc_pkg::t_div_req               div_req;
    logic [WW-1:0]                   div_divisor;
    logic                            div_busy;
    logic                            div_done;
    logic [cwc_pkg::DIV_W-1:0]       div_q;

    logic                            in_acc;
    logic                            cfg_acc;
    cwc_pkg::t_op                    op;
    cwc_pkg::t_seg                   st;
    logic [SW-1:0]                   val;
    logic [WW-1:0]                   mss_w;
    logic [cwc_pkg::THR_W-1:0]       half;
    logic [31:0]                     half32;
    logic [31:0]                     thr32;
    logic [WW-1:0]                   thr_sat;
    logic [WW-1:0]                   ss_window;
    logic [cwc_pkg::DUP_W-1:0]       dup_inc;
    logic [31:0]                     win32;

    function automatic logic [WW-1:0] add_sat(input logic [SUM_W-1:0] s);
        return (s > WMAX_EXT) ? WMAX : s[WW-1:0];
    endfunction

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign op      = cwc_pkg::t_op'(s_axis_tuser);
    assign st      = cwc_pkg::t_seg'(s_axis_tdata[33:32]);
    assign val     = s_axis_tdata[SW-1:0];
    assign mss_w   = WW'(r_mss);
    assign half32  = 32'(r_window >> 1);
    assign half    = (half32 > 32'(cwc_pkg::THR_MAX)) ? cwc_pkg::THR_MAX : half32[23:0];
    assign thr32   = 32'(r_thr);
    assign thr_sat = (thr32 > 32'(WMAX)) ? WMAX : thr32[WW-1:0];
    assign ss_window = add_sat(SUM_W'(r_window) + SUM_W'(r_mss));
    assign dup_inc = (r_dup < cwc_pkg::DUP_MAX) ? r_dup + 1'b1 : r_dup;
    assign win32   = 32'(r_window);

    assign s_axis_tready = (r_state == cwc_pkg::S_IDLE);
    assign o_cfg_ready   = (r_state == cwc_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == cwc_pkg::S_DONE);

    always_comb begin
        n_state      = r_state;
        n_mss        = r_mss;
        n_tmo        = r_tmo;
        n_window     = r_window;
        n_thr        = r_thr;
        n_phase      = r_phase;
        n_dup        = r_dup;
        n_last_ack   = r_last_ack;
        n_last_valid = r_last_valid;
        n_base       = r_base;
        n_armed      = r_armed;
        n_left       = r_left;
        n_ev         = r_ev;
        n_budget     = r_budget;
        n_sq         = r_sq;
        div_req      = '0;
        div_divisor  = r_window;

        unique case (r_state)
            cwc_pkg::S_IDLE: begin
                if (cfg_acc) begin
                    unique case (i_cfg_index)
                        cwc_pkg::CFG_MSS: begin
                            n_mss    = i_cfg_data[cwc_pkg::MSS_W-1:0];
                            n_window = WW'(i_cfg_data[cwc_pkg::MSS_W-1:0]);
                        end
                        cwc_pkg::CFG_THR: begin
                            n_thr = i_cfg_data[cwc_pkg::THR_W-1:0];
                        end
                        cwc_pkg::CFG_TMO: begin
                            n_tmo = i_cfg_data[cwc_pkg::TMR_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
                if (in_acc) begin
                    n_ev    = cwc_pkg::EV_NONE;
                    n_state = cwc_pkg::S_BUDGET;
                    unique case (op)
                        cwc_pkg::OP_ACK: begin
                            n_last_ack   = val;
                            n_last_valid = 1'b1;
                            priority if (st == cwc_pkg::SEG_ACKED) begin
                                if (r_last_valid && (r_last_ack == val)) begin
                                    n_dup = dup_inc;
                                    if (dup_inc == cwc_pkg::DUP_TRIGGER) begin
                                        n_armed  = 1'b0;
                                        n_left   = '0;
                                        n_thr    = half;
                                        n_window = add_sat(SUM_W'(half)
                                                   + SUM_W'(r_mss) + SUM_W'({r_mss, 1'b0}));
                                        n_phase  = cwc_pkg::PH_RECOVERY;
                                        n_ev     = cwc_pkg::EV_FAST;
                                    end
                                end else begin
                                    n_dup = '0;
                                end
                            end else if (st == cwc_pkg::SEG_UNACKED) begin
                                n_dup = '0;
                                if (r_base == (val - SW'(r_mss))) begin
                                    n_armed = 1'b0;
                                    n_left  = '0;
                                end
                                unique case (r_phase)
                                    cwc_pkg::PH_SLOW: begin
                                        n_window = ss_window;
                                        if (32'(ss_window) >= thr32) begin
                                            n_phase = cwc_pkg::PH_AVOID;
                                        end
                                    end
                                    cwc_pkg::PH_AVOID: begin
                                        n_state = cwc_pkg::S_MUL;
                                    end
                                    default: begin
                                        n_window = thr_sat;
                                        n_phase  = cwc_pkg::PH_AVOID;
                                    end
                                endcase
                            end else begin
                            end
                        end
                        cwc_pkg::OP_SENT: begin
                            if (!r_armed) begin
                                n_base  = val;
                                n_armed = 1'b1;
                                n_left  = r_tmo;
                            end
                        end
                        cwc_pkg::OP_TICK: begin
                            if (r_armed) begin
                                if (r_left != '0) begin
                                    n_left = r_left - 1'b1;
                                end else begin
                                    n_armed = 1'b0;
                                    if (st == cwc_pkg::SEG_UNACKED) begin
                                        n_dup    = '0;
                                        n_thr    = half;
                                        n_window = mss_w;
                                        n_phase  = cwc_pkg::PH_SLOW;
                                        n_ev     = cwc_pkg::EV_TIMEOUT;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cwc_pkg::S_MUL: begin
                n_sq    = cwc_pkg::DIV_W'(r_mss) * cwc_pkg::DIV_W'(r_mss);
                n_state = cwc_pkg::S_GROW;
            end
            cwc_pkg::S_GROW: begin
                if (r_window == '0) begin
                    n_window = add_sat(SUM_W'(r_sq));
                    n_state  = cwc_pkg::S_BUDGET;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_sq;
                    n_state          = cwc_pkg::S_GWAIT;
                end
            end
            cwc_pkg::S_GWAIT: begin
                if (div_done) begin
                    n_window = add_sat(SUM_W'(r_window) + SUM_W'(div_q));
                    n_state  = cwc_pkg::S_BUDGET;
                end
            end
            cwc_pkg::S_BUDGET: begin
                div_divisor = mss_w;
                if (r_mss == '0) begin
                    n_budget = '0;
                    n_state  = cwc_pkg::S_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = win32;
                    n_state          = cwc_pkg::S_BWAIT;
                end
            end
            cwc_pkg::S_BWAIT: begin
                div_divisor = mss_w;
                if (div_done) begin
                    n_budget = (div_q > 32'(cwc_pkg::THR_MAX)) ? cwc_pkg::THR_MAX
                                                              : div_q[23:0];
                    n_state  = cwc_pkg::S_DONE;
                end
            end
            cwc_pkg::S_DONE: begin
                if (m_axis_tready) begin
                    n_state = cwc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cwc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cwc_pkg::S_IDLE;
            r_mss        <= cwc_pkg::RST_MSS;
            r_tmo        <= cwc_pkg::RST_TMO;
            r_window     <= WW'(cwc_pkg::RST_MSS);
            r_thr        <= cwc_pkg::RST_THR;
            r_phase      <= cwc_pkg::PH_SLOW;
            r_dup        <= '0;
            r_last_ack   <= '0;
            r_last_valid <= 1'b0;
            r_base       <= '0;
            r_armed      <= 1'b0;
            r_left       <= '0;
            r_ev         <= cwc_pkg::EV_NONE;
        end else begin
            r_state      <= n_state;
            r_mss        <= n_mss;
            r_tmo        <= n_tmo;
            r_window     <= n_window;
            r_thr        <= n_thr;
            r_phase      <= n_phase;
            r_dup        <= n_dup;
            r_last_ack   <= n_last_ack;
            r_last_valid <= n_last_valid;
            r_base       <= n_base;
            r_armed      <= n_armed;
            r_left       <= n_left;
            r_ev         <= n_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_budget <= n_budget;
        r_sq     <= n_sq;
    end

    cwc_div #(
        .WINDOW_WIDTH (WINDOW_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign m_axis_tdata = {3'b000, r_armed, r_ev, r_budget, r_phase, r_thr, win32[23:0]};

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output handshakes open together");

    a_fast_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_ev == cwc_pkg::EV_FAST)) |->
        ((r_phase == cwc_pkg::PH_RECOVERY) && !r_armed))
        else $error("fast retransmit without recovery phase");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_ev == cwc_pkg::EV_TIMEOUT)) |->
        ((r_phase == cwc_pkg::PH_SLOW) && !r_armed))
        else $error("timeout without collapse to slow start");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> ((r_state == cwc_pkg::S_GWAIT) || (r_state == cwc_pkg::S_BWAIT)))
        else $error("divider running outside a wait state");

endmodule

/* tb/tb_tcp_congestion_window_control_core.sv */
// ----------------------------------------------------------------------------
// tb_tcp_congestion_window_control_core - window control core testbench
// Streams ACK, segment-sent and tick requests through the core under several
// register settings, predicts each report and compares it field by field.
// ----------------------------------------------------------------------------
module tb_tcp_congestion_window_control_core;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam logic [cwc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        cwc_pkg::t_op  op;
        logic [31:0]   seq;
        cwc_pkg::t_seg status;
    } t_cc_req;

    typedef struct packed {
        logic [23:0]     window;
        logic [23:0]     thresh;
        cwc_pkg::t_phase phase;
        logic [23:0]     budget;
        cwc_pkg::t_event retx;
        logic            timer_on;
    } t_cc_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [cwc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cwc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    tcp_congestion_window_control_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted controller state
    logic [cwc_pkg::MSS_W-1:0] mss_reg  = cwc_pkg::RST_MSS;
    logic [cwc_pkg::TMR_W-1:0] tmo_reg  = cwc_pkg::RST_TMO;
    logic [23:0]               cwnd     = 24'(cwc_pkg::RST_MSS);
    logic [cwc_pkg::THR_W-1:0] ssthresh = cwc_pkg::RST_THR;
    cwc_pkg::t_phase           cc_phase = cwc_pkg::PH_SLOW;
    logic [cwc_pkg::DUP_W-1:0] dup_acks = '0;
    logic [31:0]               last_ack = '0;
    logic                      last_ack_ok = 1'b0;
    logic [31:0]               base_seq = '0;
    logic                      rto_armed = 1'b0;
    logic [cwc_pkg::TMR_W-1:0] rto_left = '0;

    t_cc_req    pending_events[$];
    t_cc_report window_reports[$];
    t_cc_req    bus_req;

    logic [31:0] gen_ack = '0;
    int unsigned queued_total = 0;
    int unsigned reports_seen = 0;
    int unsigned mismatches = 0;
    int unsigned fast_seen = 0;
    int unsigned timeout_seen = 0;
    int unsigned settings_done = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_age = 0;
    logic [31:0] stall_pat = 32'hFFFF_FFFF;

    function automatic logic [23:0] sat_window(input longint unsigned v);
        return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

    function automatic void apply_cc_event(input t_cc_req r);
        logic [63:0] grow;
        t_cc_report  rep;
        rep.retx = cwc_pkg::EV_NONE;
        case (r.op)
            cwc_pkg::OP_ACK: begin
                if (r.status == cwc_pkg::SEG_ACKED) begin
                    if (last_ack_ok && last_ack == r.seq) begin
                        if (dup_acks < cwc_pkg::DUP_MAX) dup_acks = dup_acks + 1'b1;
                        if (dup_acks == cwc_pkg::DUP_TRIGGER) begin
                            rto_armed = 1'b0;
                            rto_left  = '0;
                            ssthresh  = cwnd >> 1;
                            cwnd      = sat_window(64'(ssthresh) + 3 * 64'(mss_reg));
                            cc_phase  = cwc_pkg::PH_RECOVERY;
                            rep.retx  = cwc_pkg::EV_FAST;
                        end
                    end else begin
                        dup_acks = '0;
                    end
                end else if (r.status == cwc_pkg::SEG_UNACKED) begin
                    dup_acks = '0;
                    if (base_seq == r.seq - 32'(mss_reg)) begin
                        rto_armed = 1'b0;
                        rto_left  = '0;
                    end
                    case (cc_phase)
                        cwc_pkg::PH_SLOW: begin
                            cwnd = sat_window(64'(cwnd) + 64'(mss_reg));
                            if (cwnd >= ssthresh) cc_phase = cwc_pkg::PH_AVOID;
                        end
                        cwc_pkg::PH_AVOID: begin
                            grow = 64'(mss_reg) * 64'(mss_reg);
                            if (cwnd != 0) grow = grow / 64'(cwnd);
                            cwnd = sat_window(64'(cwnd) + grow);
                        end
                        default: begin
                            cwnd     = ssthresh;
                            cc_phase = cwc_pkg::PH_AVOID;
                        end
                    endcase
                end
                last_ack    = r.seq;
                last_ack_ok = 1'b1;
            end
            cwc_pkg::OP_SENT: begin
                if (!rto_armed) begin
                    base_seq  = r.seq;
                    rto_armed = 1'b1;
                    rto_left  = tmo_reg;
                end
            end
            cwc_pkg::OP_TICK: begin
                if (rto_armed) begin
                    if (rto_left > 0) begin
                        rto_left = rto_left - 1'b1;
                    end else begin
                        rto_armed = 1'b0;
                        if (r.status == cwc_pkg::SEG_UNACKED) begin
                            dup_acks = '0;
                            ssthresh = cwnd >> 1;
                            cwnd     = 24'(mss_reg);
                            cc_phase = cwc_pkg::PH_SLOW;
                            rep.retx = cwc_pkg::EV_TIMEOUT;
                        end
                    end
                end
            end
            default: ;
        endcase
        rep.window   = cwnd;
        rep.thresh   = ssthresh;
        rep.phase    = cc_phase;
        rep.budget   = (mss_reg == 0) ? 24'd0 : cwnd / 24'(mss_reg);
        rep.timer_on = rto_armed;
        window_reports = {window_reports, rep};
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_req(input cwc_pkg::t_op op, input logic [31:0] seq,
                                     input cwc_pkg::t_seg st);
        t_cc_req r;
        r.op     = op;
        r.seq    = seq;
        r.status = st;
        pending_events = {pending_events, r};
        queued_total++;
    endfunction

    task automatic write_reg(input logic [cwc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cwc_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            cwc_pkg::CFG_MSS: begin
                mss_reg = data[cwc_pkg::MSS_W-1:0];
                cwnd    = 24'(data[cwc_pkg::MSS_W-1:0]);
            end
            cwc_pkg::CFG_THR: ssthresh = data[cwc_pkg::THR_W-1:0];
            cwc_pkg::CFG_TMO: tmo_reg = data[cwc_pkg::TMR_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (reports_seen < queued_total) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // well-formed ACK streams, duplicate runs and timer runs, plus some noise
    task automatic queue_traffic(input int unsigned count, input logic [15:0] mss,
                                 input logic [19:0] tmo);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        target = queued_total + count;
        while (queued_total < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) gen_ack = $urandom();
            if (pick < 38) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 1) == 1)
                        push_req(cwc_pkg::OP_SENT, gen_ack,
                                 cwc_pkg::t_seg'($urandom_range(0, 3)));
                    gen_ack = gen_ack + 32'(mss);
                    push_req(cwc_pkg::OP_ACK, gen_ack, cwc_pkg::SEG_UNACKED);
                end
            end else if (pick < 58) begin
                len = $urandom_range(1, 8);
                repeat (len) push_req(cwc_pkg::OP_ACK, gen_ack, cwc_pkg::SEG_ACKED);
            end else if (pick < 78) begin
                if ($urandom_range(0, 1) == 1)
                    push_req(cwc_pkg::OP_SENT, gen_ack,
                             cwc_pkg::t_seg'($urandom_range(0, 3)));
                len = (tmo < 10) ? $urandom_range(1, int'(tmo) + 3) : $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 4) == 0)
                        push_req(cwc_pkg::OP_TICK, $urandom(),
                                 cwc_pkg::t_seg'($urandom_range(0, 3)));
                    else
                        push_req(cwc_pkg::OP_TICK, $urandom(), cwc_pkg::SEG_UNACKED);
                end
            end else if (pick < 88) begin
                len = $urandom_range(1, 3);
                repeat (len) push_req(cwc_pkg::OP_ACK, $urandom(),
                                      cwc_pkg::t_seg'($urandom_range(2, 3)));
            end else begin
                push_req(cwc_pkg::t_op'($urandom_range(0, 3)), $urandom(),
                         cwc_pkg::t_seg'($urandom_range(0, 3)));
            end
        end
    endtask

    task automatic run_phase(input logic [23:0] mss_w, input logic [23:0] thr_w,
                             input logic [23:0] tmo_w, input int unsigned count);
        wait_drained();
        write_reg(cwc_pkg::CFG_MSS, mss_w);
        write_reg(cwc_pkg::CFG_THR, thr_w);
        write_reg(cwc_pkg::CFG_TMO, tmo_w);
        gen_ack = $urandom();
        queue_traffic(count / 2, mss_w[15:0], tmo_w[19:0]);
        // hold off the sender until every report is back
        wait_drained();
        queue_traffic(count - count / 2, mss_w[15:0], tmo_w[19:0]);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_req(cwc_pkg::OP_NONE, 32'hFFFF_FFFF, cwc_pkg::SEG_UNKNOWN);
        push_req(cwc_pkg::OP_ACK,  32'h0000_0000, cwc_pkg::SEG_ACKED);
        push_req(cwc_pkg::OP_TICK, 32'h0000_0000, cwc_pkg::SEG_UNACKED);
        push_req(cwc_pkg::OP_SENT, 32'hFFFF_FC00, cwc_pkg::SEG_ACKED);
        push_req(cwc_pkg::OP_SENT, 32'h0000_0005, cwc_pkg::SEG_UNACKED);
        push_req(cwc_pkg::OP_TICK, 32'h0000_0000, cwc_pkg::SEG_UNACKED);
        push_req(cwc_pkg::OP_ACK,  32'h0000_0000, cwc_pkg::SEG_UNACKED);
        repeat (8) push_req(cwc_pkg::OP_ACK, 32'h0000_0000, cwc_pkg::SEG_ACKED);
        push_req(cwc_pkg::OP_ACK,  32'h0000_0400, cwc_pkg::SEG_UNACKED);
        push_req(cwc_pkg::OP_ACK,  32'h0000_0800, cwc_pkg::SEG_UNACKED);
        push_req(cwc_pkg::OP_ACK,  32'hFFFF_FFFF, cwc_pkg::SEG_OUTSIDE);
        push_req(cwc_pkg::OP_ACK,  32'h1234_5678, cwc_pkg::SEG_UNKNOWN);
        push_req(cwc_pkg::OP_ACK,  32'h0000_0007, cwc_pkg::SEG_ACKED);
        push_req(cwc_pkg::OP_TICK, 32'hFFFF_FFFF, cwc_pkg::SEG_ACKED);
        push_req(cwc_pkg::OP_SENT, 32'h0000_0000, cwc_pkg::SEG_OUTSIDE);
        push_req(cwc_pkg::OP_TICK, 32'h0000_0000, cwc_pkg::SEG_OUTSIDE);
        push_req(cwc_pkg::OP_NONE, 32'h0000_0000, cwc_pkg::SEG_ACKED);

        run_phase(24'd1460, 24'd8000, 24'hF0_0003, 300);
        run_phase(24'd1, 24'd1, 24'd1, 300);
        run_phase(24'h00_FFFF, 24'hFF_FFFF, 24'h0F_FFFF, 200);
        run_phase(24'hFF_FFFF, 24'd1000, 24'd4, 200);
        wait_drained();
        write_reg(CFG_IDX_SPARE, 24'hFF_FFFF);
        // zero segment size, zero threshold, zero timeout
        run_phase(24'h01_0000, 24'd0, 24'h10_0000, 250);
        run_phase(24'd536, 24'd30000, 24'd10, 300);
        run_phase(24'd1024, 24'd65536, 24'd5, 250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (window_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, window_reports.size());
            mismatches++;
        end
        $display("Ran %0d requests under %0d register writes, directed corners first.",
                 queued_total, settings_done);
        $display("Observed %0d fast retransmits and %0d timeouts; %0d mismatches.",
                 fast_seen, timeout_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) apply_cc_event(bus_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    bus_req = pending_events.pop_front();
                    s_axis_tuser  <= bus_req.op;
                    s_axis_tdata  <= {6'b0, bus_req.status, bus_req.seq};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        case ($urandom_range(0, 3))
                            0: begin
                                burst_left = $urandom_range(20, 60);
                                gap_left   = 0;
                            end
                            1: begin
                                burst_left = $urandom_range(0, 7);
                                gap_left   = $urandom_range(1, 4);
                            end
                            2: begin
                                burst_left = $urandom_range(0, 7);
                                gap_left   = $urandom_range(5, 50);
                            end
                            default: begin
                                burst_left = $urandom_range(0, 7);
                                gap_left   = $urandom_range(1, 12);
                            end
                        endcase
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // report sink: rotating stall pattern, reshuffled now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_age == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 32'hFFFF_FFFF;
                    1: stall_pat = $urandom() | 32'd1;
                    2: stall_pat = ($urandom() & $urandom()) | 32'd1;
                    default: stall_pat = $urandom() | $urandom() | 32'd1;
                endcase
                stall_age = $urandom_range(50, 300);
            end else begin
                stall_age--;
            end
            stall_pat = {stall_pat[0], stall_pat[31:1]};
            m_axis_tready <= stall_pat[0];
        end
    end

    always @(posedge i_clk) begin
        t_cc_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_reports.size() == 0) begin
                $display("%0t: unexpected report: expected none, actual %0h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = window_reports.pop_front();
                check_field("window_bytes", want.window, m_axis_tdata[23:0]);
                check_field("threshold_bytes", want.thresh, m_axis_tdata[47:24]);
                check_field("phase", want.phase, m_axis_tdata[49:48]);
                check_field("send_budget", want.budget, m_axis_tdata[73:50]);
                check_field("retransmit_event", want.retx, m_axis_tdata[75:74]);
                check_field("timer_active", want.timer_on, m_axis_tdata[76]);
                if (want.retx == cwc_pkg::EV_FAST) fast_seen++;
                if (want.retx == cwc_pkg::EV_TIMEOUT) timeout_seen++;
                reports_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d of %0d reports", $time,
                     reports_seen, queued_total);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

/* files.f */
hdl/cwc_pkg.sv
hdl/cwc_div.sv
hdl/tcp_congestion_window_control_core.sv
tb/tb_tcp_congestion_window_control_core.sv
